/* rtl/core/vpg_pkg.sv */
// ----------------------------------------------------------------------------
// vpg_pkg
// Shared types and constants for the trapezoidal velocity profile generator:
// profile phase codes, register map and register reset values.
// ----------------------------------------------------------------------------
package vpg_pkg;

  // Default fixed-point format (Q4.12)
  localparam int unsigned FRACTION_BITS_DEF = 12;

  // Bus widths
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DIST_W     = 16;

  // Profile phase
  typedef enum logic [1:0] {
    PH_ACCEL = 2'd0,
    PH_CONST = 2'd1,
    PH_DECEL = 2'd2
  } phase_t;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_MAX_SPEED      = 3'd0,
    REG_MIN_SPEED      = 3'd1,
    REG_ACCEL_PROP     = 3'd2,
    REG_ACCEL_INTEG    = 3'd3,
    REG_BRAKE_GAIN     = 3'd4,
    REG_BRAKE_START    = 3'd5,
    REG_FINAL_APPROACH = 3'd6
  } reg_idx_t;

  // Register reset values
  localparam logic [LIMIT_W-1:0] MAX_SPEED_RST      = 15'd2048;
  localparam logic [LIMIT_W-1:0] MIN_SPEED_RST      = 15'd410;
  localparam logic [GAIN_W-1:0]  ACCEL_PROP_RST     = 16'd2048;
  localparam logic [GAIN_W-1:0]  ACCEL_INTEG_RST    = 16'd2867;
  localparam logic [GAIN_W-1:0]  BRAKE_GAIN_RST     = 16'd12288;
  localparam logic [DIST_W-1:0]  BRAKE_START_RST    = 16'd410;
  localparam logic [DIST_W-1:0]  FINAL_APPROACH_RST = 16'd123;

endpackage

/* rtl/core/velocity_profile_generator.sv */
// ----------------------------------------------------------------------------
// velocity_profile_generator
// Three-phase (accelerate / constant / decelerate) speed profile for one axis
// with a PI-style ramp, distance-driven braking and an APB register file.
// ----------------------------------------------------------------------------
// Throughput is one beat per clock while results are taken: a beat is captured
// in an input register, and when it advances the two gain multiplies, the sum
// and the clamps run in one combinational pass into the result register, which
// also updates phase, accumulated gap and braking entry speed, so the following
// beat already sees the new state. Result valid rises as the beat moves from the
// input register into the result register. The pass is limited by one 16x16
// multiply followed by a 27-bit add and compare. A held result stalls the input
// only when both registers are full.
module velocity_profile_generator
  import vpg_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [15:0] present_speed, [31:16] distance_left
  input  logic [0:0]            s_tuser,   // [0] start_move
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [15:0] new_speed
  output logic [1:0]            m_tuser,   // [1:0] phase_now
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned GAP_W  = FRACTION_BITS + 2;
  localparam int unsigned IPROD_W = GAIN_W + GAP_W;
  localparam int unsigned SUM_W  = 27;
  localparam int unsigned ACC_W  = 18;
  localparam int unsigned DEC_W  = 26;
  localparam logic [GAP_W-1:0] SUM_CAP = GAP_W'(3) << FRACTION_BITS;

  // Configuration registers
  logic [LIMIT_W-1:0] max_speed;
  logic [LIMIT_W-1:0] min_speed;
  logic [GAIN_W-1:0]  accel_prop_gain;
  logic [GAIN_W-1:0]  accel_integral_gain;
  logic [GAIN_W-1:0]  brake_distance_gain;
  logic [DIST_W-1:0]  brake_start_distance;
  logic [DIST_W-1:0]  final_approach_distance;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  // Write registers; an index beyond the map is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed               <= MAX_SPEED_RST;
      min_speed               <= MIN_SPEED_RST;
      accel_prop_gain         <= ACCEL_PROP_RST;
      accel_integral_gain     <= ACCEL_INTEG_RST;
      brake_distance_gain     <= BRAKE_GAIN_RST;
      brake_start_distance    <= BRAKE_START_RST;
      final_approach_distance <= FINAL_APPROACH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MAX_SPEED:      max_speed               <= pwdata[LIMIT_W-1:0];
        REG_MIN_SPEED:      min_speed               <= pwdata[LIMIT_W-1:0];
        REG_ACCEL_PROP:     accel_prop_gain         <= pwdata[GAIN_W-1:0];
        REG_ACCEL_INTEG:    accel_integral_gain     <= pwdata[GAIN_W-1:0];
        REG_BRAKE_GAIN:     brake_distance_gain     <= pwdata[GAIN_W-1:0];
        REG_BRAKE_START:    brake_start_distance    <= pwdata[DIST_W-1:0];
        REG_FINAL_APPROACH: final_approach_distance <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (cfg_idx)
      REG_MAX_SPEED:      prdata = CFG_DATA_W'(max_speed);
      REG_MIN_SPEED:      prdata = CFG_DATA_W'(min_speed);
      REG_ACCEL_PROP:     prdata = CFG_DATA_W'(accel_prop_gain);
      REG_ACCEL_INTEG:    prdata = CFG_DATA_W'(accel_integral_gain);
      REG_BRAKE_GAIN:     prdata = CFG_DATA_W'(brake_distance_gain);
      REG_BRAKE_START:    prdata = CFG_DATA_W'(brake_start_distance);
      REG_FINAL_APPROACH: prdata = CFG_DATA_W'(final_approach_distance);
      default:            prdata = '0;
    endcase
  end

  // Input register and stage handshake
  logic                      in_valid;
  logic signed [SPEED_W-1:0] in_speed;
  logic [DIST_W-1:0]         in_dist;
  logic                      in_start;
  logic                      advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_speed <= $signed(s_tdata[15:0]);
      in_dist  <= s_tdata[31:16];
      in_start <= s_tuser[0];
    end
  end

  // Profile state
  phase_t                    phase;
  logic [GAP_W-1:0]          gap_sum;
  logic signed [SPEED_W-1:0] brake_entry_speed;

  phase_t                    phase_next;
  logic [GAP_W-1:0]          gap_sum_next;
  logic signed [SPEED_W-1:0] brake_entry_speed_next;
  logic signed [SPEED_W-1:0] speed_next;

  // Datapath terms
  phase_t                    phase_eff;
  logic [GAP_W-1:0]          gap_eff;
  logic signed [SPEED_W:0]   gap_diff;
  logic [SPEED_W-1:0]        gap_abs;
  logic [31:0]               prop_prod;
  logic [IPROD_W-1:0]        integ_prod;
  logic [SUM_W-1:0]          prop_term;
  logic [SUM_W-1:0]          integ_term;
  logic signed [SUM_W-1:0]   accel_sum;
  logic signed [SPEED_W-1:0] accel_speed;
  logic [SPEED_W:0]          headroom;
  logic [ACC_W-1:0]          gap_acc;
  logic                      near_brake;
  logic [31:0]               dist_prod;
  logic signed [DEC_W-1:0]   dec_speed;

  always_comb begin
    // Start flag restarts the profile
    phase_eff = in_start ? PH_ACCEL : phase;
    gap_eff   = in_start ? '0 : gap_sum;

    // Accelerate: PI step on the gap to maximum
    gap_diff   = SPEED_W'(in_speed) - $signed({2'b00, max_speed});
    gap_abs    = gap_diff[SPEED_W] ? SPEED_W'(-gap_diff) : gap_diff[SPEED_W-1:0];
    prop_prod  = accel_prop_gain * gap_abs;
    integ_prod = IPROD_W'(accel_integral_gain) * IPROD_W'(gap_eff);
    prop_term  = SUM_W'(prop_prod >> FRACTION_BITS);
    integ_term = SUM_W'(integ_prod >> FRACTION_BITS);
    accel_sum  = SUM_W'(in_speed) + $signed(prop_term) + $signed(integ_term);
    if (accel_sum > $signed(SUM_W'(max_speed))) begin
      accel_speed = $signed(SPEED_W'(max_speed));
    end else begin
      accel_speed = accel_sum[SPEED_W-1:0];
    end
    // Accumulate the remaining gap, capped
    headroom = (SPEED_W+1)'(max_speed) - (SPEED_W+1)'(accel_speed);
    gap_acc  = ACC_W'(gap_eff) + ACC_W'(headroom);

    near_brake = in_dist < brake_start_distance;

    // Decelerate: speed follows remaining distance
    dist_prod = brake_distance_gain * in_dist;
    dec_speed = $signed(DEC_W'(dist_prod >> FRACTION_BITS));
    if (dec_speed > DEC_W'(brake_entry_speed)) dec_speed = DEC_W'(brake_entry_speed);
    if (dec_speed > $signed(DEC_W'(max_speed))) dec_speed = $signed(DEC_W'(max_speed));
    if (dec_speed < $signed(DEC_W'(min_speed))) dec_speed = $signed(DEC_W'(min_speed));
    if (in_dist < final_approach_distance) dec_speed = $signed(DEC_W'(min_speed));

    // Phase selection
    phase_next             = phase_eff;
    gap_sum_next           = gap_eff;
    brake_entry_speed_next = brake_entry_speed;
    unique case (phase_eff)
      PH_ACCEL: begin
        speed_next   = accel_speed;
        gap_sum_next = (gap_acc > ACC_W'(SUM_CAP)) ? SUM_CAP : gap_acc[GAP_W-1:0];
        if (accel_speed >= $signed(SPEED_W'(max_speed))) begin
          phase_next = PH_CONST;
        end else if (near_brake) begin
          brake_entry_speed_next = accel_speed;
          phase_next             = PH_DECEL;
        end
      end
      PH_CONST: begin
        speed_next = $signed(SPEED_W'(max_speed));
        if (near_brake) begin
          brake_entry_speed_next = $signed(SPEED_W'(max_speed));
          phase_next             = PH_DECEL;
        end
      end
      default: begin
        speed_next = dec_speed[SPEED_W-1:0];
        phase_next = PH_DECEL;
      end
    endcase
  end

  // Commit state on each processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_ACCEL;
      gap_sum           <= '0;
      brake_entry_speed <= '0;
    end else if (advance) begin
      phase             <= phase_next;
      gap_sum           <= gap_sum_next;
      brake_entry_speed <= brake_entry_speed_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= speed_next;
      m_tuser <= phase_next;
    end
  end

  // Checks
  a_gap_capped: assert property (@(posedge clk) disable iff (rst)
    gap_sum <= SUM_CAP)
    else $error("accumulated gap above cap");

  a_decel_sticky: assert property (@(posedge clk) disable iff (rst)
    advance && !in_start && phase == PH_DECEL |=> phase == PH_DECEL)
    else $error("left decelerate without start");

  a_const_at_max: assert property (@(posedge clk) disable iff (rst)
    advance && phase_next == PH_CONST |=> m_tdata == SPEED_W'(max_speed))
    else $error("constant phase result not at maximum speed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a full pipeline");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for velocity_profile_generator. A beat-level profile
// predictor tracks phase, accumulated gap and braking entry speed, and each
// result beat is compared with the oldest predicted speed and phase. Stimulus
// is a directed profile walk followed by randomized moves (start beat, falling
// distance, speed fed back from the prediction) under several register sets,
// with bursty input traffic and a stalling result side.
// ----------------------------------------------------------------------------
module testbench;
  import vpg_pkg::*;

  localparam int unsigned FRAC         = FRACTION_BITS_DEF;
  localparam longint      GAP_CAP      = longint'(3) << FRAC;
  localparam logic [2:0]  REG_UNUSED   = 3'd7;
  localparam int          RANDOM_ITEMS = 1320;
  localparam int          RANDOM_SETS  = 8;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          STUCK_LIMIT  = 4000;

  typedef struct packed {
    logic signed [15:0] speed;
    phase_t             ph;
  } speed_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata  = '0;  // [15:0] present_speed, [31:16] distance_left
  logic [0:0]            s_tuser  = '0;  // [0] start_move
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;        // [15:0] new_speed
  logic [1:0]            m_tuser;        // [1:0] phase_now
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Register shadow
  logic [LIMIT_W-1:0] cfg_vmax        = MAX_SPEED_RST;
  logic [LIMIT_W-1:0] cfg_vmin        = MIN_SPEED_RST;
  logic [GAIN_W-1:0]  cfg_prop_gain   = ACCEL_PROP_RST;
  logic [GAIN_W-1:0]  cfg_integ_gain  = ACCEL_INTEG_RST;
  logic [GAIN_W-1:0]  cfg_brake_gain  = BRAKE_GAIN_RST;
  logic [DIST_W-1:0]  cfg_brake_start = BRAKE_START_RST;
  logic [DIST_W-1:0]  cfg_final_dist  = FINAL_APPROACH_RST;

  // Profile state as the block should hold it
  phase_t             run_phase   = PH_ACCEL;
  logic [13:0]        gap_accum   = '0;
  logic signed [15:0] entry_speed = '0;
  logic signed [15:0] last_speed  = '0;

  speed_result_t pending_speeds[$];
  speed_result_t want;
  int            mismatch_count = 0;
  int            burst_left     = 0;
  bit            steady_flow    = 1'b0;
  int            stuck_cycles   = 0;
  rx_mode_t      stall_mode     = RX_OPEN;
  int            stall_left     = 0;
  logic [7:0]    stall_tick     = '0;
  logic          rx_go;

  velocity_profile_generator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the profile by one beat and return the expected result
  function automatic speed_result_t profile_step(logic signed [15:0] spd,
                                                 logic [15:0] dist_in, logic start);
    speed_result_t r;
    longint v, gap, acc, vmax, vmin, prop, integ, sum;
    v     = spd;
    vmax  = cfg_vmax;
    vmin  = cfg_vmin;
    prop  = cfg_prop_gain;
    integ = cfg_integ_gain;
    if (start) begin
      run_phase = PH_ACCEL;
      gap_accum = '0;
    end
    sum = gap_accum;
    case (run_phase)
      PH_ACCEL: begin
        gap = (v > vmax) ? v - vmax : vmax - v;
        v = v + ((prop * gap) >> FRAC) + ((integ * sum) >> FRAC);
        if (v > vmax) v = vmax;
        acc = sum + vmax - v;
        if (acc > GAP_CAP) acc = GAP_CAP;
        gap_accum = acc[13:0];
        if (v >= vmax) begin
          run_phase = PH_CONST;
        end else if (dist_in < cfg_brake_start) begin
          entry_speed = v[15:0];
          run_phase   = PH_DECEL;
        end
      end
      PH_CONST: begin
        v = vmax;
        if (dist_in < cfg_brake_start) begin
          entry_speed = v[15:0];
          run_phase   = PH_DECEL;
        end
      end
      default: begin
        // braking: distance law, entry speed, max and min clamps, then final approach
        run_phase = PH_DECEL;
        v = (longint'(cfg_brake_gain) * longint'(dist_in)) >> FRAC;
        if (v > entry_speed) v = entry_speed;
        if (v > vmax) v = vmax;
        if (v < vmin) v = vmin;
        if (dist_in < cfg_final_dist) v = vmin;
      end
    endcase
    r.speed    = v[15:0];
    r.ph       = run_phase;
    last_speed = r.speed;
    return r;
  endfunction

  // Send one input beat, idling between bursts
  task automatic send_beat(input logic [15:0] spd, input logic [15:0] dist_in,
                           input logic start);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_flow && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {dist_in, spd};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    pending_speeds.push_back(profile_step(spd, dist_in, start));
  endtask

  // Drop valid and hold until every expected beat has come back
  task automatic wait_idle();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase until pready, then back to idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MAX_SPEED:      cfg_vmax        = val[14:0];
      REG_MIN_SPEED:      cfg_vmin        = val[14:0];
      REG_ACCEL_PROP:     cfg_prop_gain   = val[15:0];
      REG_ACCEL_INTEG:    cfg_integ_gain  = val[15:0];
      REG_BRAKE_GAIN:     cfg_brake_gain  = val[15:0];
      REG_BRAKE_START:    cfg_brake_start = val[15:0];
      REG_FINAL_APPROACH: cfg_final_dist  = val[15:0];
      default: ;
    endcase
  endtask

  // Walk the default profile through every phase and its corner cases
  task automatic test_directed_profile();
    send_beat(16'h0000, 16'hFFFF, 1'b1);
    send_beat(last_speed, 16'hFFFF, 1'b0);
    // cruising ignores the present speed
    send_beat(16'h8000, 16'h8000, 1'b0);
    send_beat(16'h7FFF, BRAKE_START_RST, 1'b0);
    send_beat(last_speed, BRAKE_START_RST - 16'd1, 1'b0);
    send_beat(16'h0000, 16'd300, 1'b0);
    send_beat(16'h0000, FINAL_APPROACH_RST, 1'b0);
    send_beat(16'h0000, FINAL_APPROACH_RST - 16'd1, 1'b0);
    // braking never returns to cruise on its own
    send_beat(16'h0000, 16'hFFFF, 1'b0);
    // negative present speed widens the gap
    send_beat(16'h8000, 16'hFFFF, 1'b1);
    send_beat(16'h7FFF, 16'hFFFF, 1'b0);
    // reaching max wins over the brake distance
    send_beat(16'h7FFF, 16'h0000, 1'b1);
    send_beat(16'h0000, 16'h0000, 1'b0);
    send_beat(16'h0000, 16'h0000, 1'b1);
    send_beat(16'h0000, 16'h0000, 1'b0);
    // negative braking entry speed falls to the creep speed
    send_beat(16'h8000, 16'h0000, 1'b1);
    send_beat(16'h0000, 16'd200, 1'b0);
  endtask

  // A write past the register map must change nothing
  task automatic test_unused_address();
    wait_idle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_beat(16'h0000, 16'h4000, 1'b1);
    send_beat(last_speed, 16'h4000, 1'b0);
    send_beat(last_speed, 16'd100, 1'b0);
  endtask

  // Creep speed above max: the minimum clamp wins while braking
  task automatic test_min_above_max();
    wait_idle();
    write_reg(REG_MAX_SPEED, 32'd100);
    write_reg(REG_MIN_SPEED, 32'd5000);
    send_beat(16'h0000, 16'd1000, 1'b1);
    send_beat(last_speed, 16'd300, 1'b0);
    send_beat(last_speed, 16'd300, 1'b0);
    send_beat(16'h0000, 16'd200, 1'b0);
    send_beat(16'h0000, 16'd50, 1'b0);
  endtask

  // Program every register; set 0 all zero, set 1 all ones, then random
  task automatic load_random_config(input int set_no);
    logic [31:0] full, val;
    for (int i = REG_MAX_SPEED; i <= REG_FINAL_APPROACH; i++) begin
      full = (i == REG_MAX_SPEED || i == REG_MIN_SPEED) ? 32'h7FFF : 32'hFFFF;
      case (set_no)
        0: val = '0;
        1: val = full;
        default: begin
          case ($urandom_range(0, 9))
            0: val = '0;
            1: val = full;
            default: val = $urandom & full;
          endcase
        end
      endcase
      // junk above the register width is dropped
      if ($urandom_range(0, 3) == 0) val = val | ($urandom & ~full);
      write_reg(i[2:0], val);
    end
  endtask

  // Moves: start beat, falling distance, speed fed back; some noise beats
  task automatic run_moves(input int n_items);
    int sent, len, d, stride;
    logic [15:0] spd;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len    = $urandom_range(3, 40);
        d      = ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(0, 65535);
        stride = d / len + 1;
        for (int k = 0; k < len && sent < n_items; k++) begin
          spd = ($urandom_range(0, 7) == 0) ? 16'($urandom) : last_speed;
          send_beat(spd, d[15:0], k == 0);
          sent++;
          d = d - stride + $urandom_range(0, stride / 2) - $urandom_range(0, stride / 2);
          if (d < 0 || k == len - 2) d = 0;
          if (d > 65535) d = 65535;
        end
      end
    end
  endtask

  task automatic test_random_moves();
    for (int s = 0; s < RANDOM_SETS; s++) begin
      wait_idle();
      load_random_config(s);
      steady_flow = (s == 2 || s == 5);
      run_moves(RANDOM_ITEMS / RANDOM_SETS);
    end
    steady_flow = 1'b0;
  endtask

  // Result side stalls in randomly chosen patterns, except during steady flow
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 8'd1;
    case (stall_mode)
      RX_OPEN:   rx_go = 1'b1;
      RX_COIN:   rx_go = $urandom_range(0, 1);
      RX_SPARSE: rx_go = ($urandom_range(0, 3) == 0);
      default:   rx_go = stall_tick[3] | stall_tick[1];
    endcase
    m_tready <= steady_flow | rx_go;
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_speeds.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: speed %0d phase %0d",
                   $signed(m_tdata), m_tuser);
      end else begin
        want = pending_speeds.pop_front();
        if (m_tdata !== want.speed || m_tuser !== want.ph) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected speed %0d phase %0d, got %0d phase %0d",
                     want.speed, want.ph, $signed(m_tdata), m_tuser);
        end
      end
    end
  end

  // Give up when no handshake of any kind happens for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_profile();
    test_unused_address();
    test_min_above_max();
    test_random_moves();
    wait_idle();
    if (mismatch_count == 0 && pending_speeds.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
